[hdl/addressable_led_bit_encoder_macros.svh]
// Assertion macros for the addressable LED bit encoder checker.
`ifndef ADDRESSABLE_LED_BIT_ENCODER_MACROS_SVH
`define ADDRESSABLE_LED_BIT_ENCODER_MACROS_SVH

// Check that a condition implies another in the same cycle, outside reset.
`define ALE_ASSERT_SAME(label, clk, rst, cond, expect_now) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
      else $error("%m: assertion failed");

// Check that a condition implies another in the next cycle, outside reset.
`define ALE_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
      else $error("%m: assertion failed");

// Check a next-cycle implication that also holds across reset.
`define ALE_ASSERT_ALWAYS_NEXT(label, clk, cond, expect_next) \
   label: assert property (@(posedge clk) (cond) |=> (expect_next)) \
      else $error("%m: assertion failed");

`endif

[hdl/ale_pkg.sv]
// Shared types and constants of the addressable LED bit encoder.
`timescale 1ns / 1ps

package ale_pkg;

   // Widths fixed by the field and register formats
   localparam int CFG_W           = 10;
   localparam int BYTE_W          = 8;
   localparam int BITS_LEFT_W     = 4;
   localparam int CSR_INDEX_W     = 2;
   localparam int BITS_PER_BYTE   = 8;
   localparam int TICK_COUNT_BITS = 10;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_HIGH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_PERIOD = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0] ZERO_HIGH_RESET  = 10'd27;
   localparam logic [CFG_W-1:0] ONE_HIGH_RESET   = 10'd45;
   localparam logic [CFG_W-1:0] BIT_PERIOD_RESET = 10'd90;

   // Bits loaded into the bit counter with each new byte
   localparam logic [BITS_LEFT_W-1:0] BITS_LOAD = BITS_LEFT_W'(BITS_PER_BYTE);

   typedef struct packed {
      logic [CFG_W-1:0] zero_high_ticks;
      logic [CFG_W-1:0] one_high_ticks;
      logic [CFG_W-1:0] bit_period_ticks;
   } cfg_type;

   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] byte_value;
      logic              last_of_frame;
   } item_type;

   typedef struct packed {
      logic line_level;
      logic byte_taken;
      logic frame_done;
      logic encoder_busy;
   } result_type;

endpackage

[hdl/addressable_led_bit_encoder.sv]
// A tick item accepted into the input register passes through the encoder into the result
//    register, and stays at the result ports while rsp_ready is low.
// Throughput: one tick item per cycle unless rsp_ready stalls the result register;
//    the encoder state advances once per item between the input and result registers.
// Configuration writes take effect at the edge that accepts them; csr_ready is always high.
// Reset (synchronous, active high) clears both registers' valid flags, idles the encoder
//    and loads the timing registers with 27, 45 and 90 ticks.
`timescale 1ns / 1ps

module addressable_led_bit_encoder #(
   parameter int TICK_COUNT_BITS = ale_pkg::TICK_COUNT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_byte_valid,
   input  logic [ale_pkg::BYTE_W-1:0]      req_byte_value,
   input  logic                            req_last_of_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_line_level,
   output logic                            rsp_byte_taken,
   output logic                            rsp_frame_done,
   output logic                            rsp_encoder_busy,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ale_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ale_pkg::CFG_W-1:0]       csr_data
);

   ale_pkg::cfg_type    cfg;
   ale_pkg::item_type   req_item;
   ale_pkg::item_type   item;
   ale_pkg::result_type result;
   ale_pkg::result_type rsp_result;
   logic                item_valid;
   logic                advance;

   // Pack request fields
   assign req_item.byte_valid    = req_byte_valid;
   assign req_item.byte_value    = req_byte_value;
   assign req_item.last_of_frame = req_last_of_frame;

   assign csr_ready = 1'b1;

   ale_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ale_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ale_encoder #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_encoder (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   ale_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   // Unpack result fields
   assign rsp_line_level   = rsp_result.line_level;
   assign rsp_byte_taken   = rsp_result.byte_taken;
   assign rsp_frame_done   = rsp_result.frame_done;
   assign rsp_encoder_busy = rsp_result.encoder_busy;

endmodule

[hdl/ale_csr.sv]
// Configuration registers of the addressable LED bit encoder.
`timescale 1ns / 1ps

module ale_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [ale_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ale_pkg::CFG_W-1:0]       csr_data,
   output ale_pkg::cfg_type                cfg
);

   ale_pkg::cfg_type cfg_ff;
   ale_pkg::cfg_type cfg_in;

   // Select the register that a write updates; ignore unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ale_pkg::REG_ZERO_HIGH:  cfg_in.zero_high_ticks  = csr_data;
            ale_pkg::REG_ONE_HIGH:   cfg_in.one_high_ticks   = csr_data;
            ale_pkg::REG_BIT_PERIOD: cfg_in.bit_period_ticks = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_high_ticks  <= ale_pkg::ZERO_HIGH_RESET;
         cfg_ff.one_high_ticks   <= ale_pkg::ONE_HIGH_RESET;
         cfg_ff.bit_period_ticks <= ale_pkg::BIT_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/ale_in_reg.sv]
// Input register that holds one tick item until the encoder consumes it.
`timescale 1ns / 1ps

module ale_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ale_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output ale_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   ale_pkg::item_type item_ff;

   // Take a new item when empty or when the held one moves on
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload; load it only on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/ale_encoder.sv]
// Bit cell state and per-tick line coding of the LED encoder.
`timescale 1ns / 1ps

module ale_encoder #(
   parameter int TICK_COUNT_BITS = ale_pkg::TICK_COUNT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  ale_pkg::cfg_type    cfg,
   input  ale_pkg::item_type   item,
   input  logic                advance,
   output ale_pkg::result_type result
);

   localparam int CmpW = ((TICK_COUNT_BITS > ale_pkg::CFG_W) ?
                          TICK_COUNT_BITS : ale_pkg::CFG_W) + 1;

   logic [ale_pkg::BYTE_W-1:0]      shift_ff, shift_in;
   logic [ale_pkg::BITS_LEFT_W-1:0] bits_left_ff, bits_left_in;
   logic [TICK_COUNT_BITS-1:0]      tick_ff, tick_in;
   logic                            active_ff, active_in;
   logic                            ending_ff, ending_in;

   logic                            cell_end;
   logic                            byte_end;
   logic                            taken;
   logic [ale_pkg::CFG_W-1:0]       high_ticks;
   logic [CmpW-1:0]                 tick_next_ext;

   // Decode cell and byte boundaries from the current tick count
   assign tick_next_ext = CmpW'(tick_ff) + CmpW'(1);
   assign cell_end = active_ff &&
                     ((tick_next_ext >= CmpW'(cfg.bit_period_ticks)) || (&tick_ff));
   assign byte_end = cell_end && (bits_left_ff <= ale_pkg::BITS_LEFT_W'(1));
   assign taken    = item.byte_valid && (!active_ff || byte_end);
   assign high_ticks = shift_ff[ale_pkg::BYTE_W-1] ? cfg.one_high_ticks
                                                   : cfg.zero_high_ticks;

   // Form this tick's outputs from the state at its start
   always_comb begin
      result.line_level   = active_ff && (CmpW'(tick_ff) < CmpW'(high_ticks));
      result.byte_taken   = taken;
      result.frame_done   = byte_end && ending_ff;
      result.encoder_busy = active_ff;
   end

   // Advance the state by one tick
   always_comb begin
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      tick_in      = tick_ff;
      active_in    = active_ff;
      ending_in    = ending_ff;
      if (taken) begin
         shift_in     = item.byte_value;
         bits_left_in = ale_pkg::BITS_LOAD;
         tick_in      = '0;
         active_in    = 1'b1;
         ending_in    = item.last_of_frame;
      end else if (byte_end) begin
         shift_in     = '0;
         bits_left_in = '0;
         tick_in      = '0;
         active_in    = 1'b0;
         ending_in    = 1'b0;
      end else if (cell_end) begin
         shift_in     = {shift_ff[ale_pkg::BYTE_W-2:0], 1'b0};
         bits_left_in = bits_left_ff - ale_pkg::BITS_LEFT_W'(1);
         tick_in      = '0;
      end else if (active_ff) begin
         tick_in      = tick_ff + TICK_COUNT_BITS'(1);
      end
   end

   // Update state only when the held item is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bits_left_ff <= '0;
         tick_ff      <= '0;
         active_ff    <= 1'b0;
         ending_ff    <= 1'b0;
      end else if (advance) begin
         shift_ff     <= shift_in;
         bits_left_ff <= bits_left_in;
         tick_ff      <= tick_in;
         active_ff    <= active_in;
         ending_ff    <= ending_in;
      end
   end

endmodule

[hdl/ale_out_reg.sv]
// Result register that holds one output item until the consumer takes it.
`timescale 1ns / 1ps

module ale_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  ale_pkg::result_type result,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ale_pkg::result_type rsp_result
);

   logic                valid_ff;
   logic                valid_in;
   logic                load_ok;
   ale_pkg::result_type result_ff;

   // Accept a new result when empty or when the held one drains
   assign load_ok  = !valid_ff || rsp_ready;
   assign advance  = item_valid && load_ok;
   assign valid_in = load_ok ? item_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

[hdl/ale_checker.sv]
// Port-level checker of the LED encoder and its bind to the top level.
`timescale 1ns / 1ps
`include "addressable_led_bit_encoder_macros.svh"

module ale_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_line_level,
   input logic rsp_byte_taken,
   input logic rsp_frame_done,
   input logic rsp_encoder_busy
);

   logic [3:0] rsp_fields;

   // Gather the result fields
   assign rsp_fields = {rsp_line_level, rsp_byte_taken, rsp_frame_done, rsp_encoder_busy};

   // An idle encoder keeps the line low
   `ALE_ASSERT_SAME(a_idle_line_low, clock, reset, rsp_valid && rsp_line_level, rsp_encoder_busy)

   // A frame can only end while a bit cell is driven
   `ALE_ASSERT_SAME(a_done_when_busy, clock, reset, rsp_valid && rsp_frame_done, rsp_encoder_busy)

   // Reset empties the result register
   `ALE_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // A stalled item holds its fields
   `ALE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fields))

endmodule

bind addressable_led_bit_encoder ale_checker u_ale_checker (.*);
